>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication checked on every rising edge of clk_i outside reset
`define ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// plain invariant checked on every rising edge of clk_i outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
`else
`define ASSERT_IMPL(lbl, pre, post, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> design/ssec_pkg.sv
// ----------------------------------------------------------------------------
// ssec_pkg
// shared constants, types and segment table of the eased cross-fade block
// ----------------------------------------------------------------------------
package ssec_pkg;

  // fraction bits of the time fraction and of the eased progress
  localparam int PROGRESS_BITS = 16;
  localparam int CNT_W         = $clog2(PROGRESS_BITS);

  localparam int MT_W      = 16;  // morph time register
  localparam int ELAPSED_W = 17;  // saturating elapsed time
  localparam int DELTA_W   = 16;
  localparam int DIGIT_W   = 4;
  localparam int SEG_N     = 7;
  localparam int LEVEL_W   = 8;

  localparam int IN_DATA_W  = 24;  // digit, elapsed, padding
  localparam int IN_USER_W  = 2;   // force, load
  localparam int OUT_DATA_W = 72;  // levels, shown, goal, in_transition, padding

  localparam logic [MT_W-1:0]      MORPH_TIME_RESET = MT_W'(100);
  localparam logic [DIGIT_W-1:0]   DIGIT_MAX        = DIGIT_W'(9);
  localparam logic [ELAPSED_W-1:0] ELAPSED_SAT      = '1;
  localparam logic [LEVEL_W-1:0]   LEVEL_FULL       = '1;
  localparam logic [PROGRESS_BITS:0] PROG_ONE = {1'b1, {PROGRESS_BITS{1'b0}}};
  localparam logic [PROGRESS_BITS:0] PROG_MAX = {1'b0, {PROGRESS_BITS{1'b1}}};

  // controller to datapath
  typedef struct packed {
    logic load;      // input transfer: digit update, time advance
    logic div_step;  // one restoring divider iteration
    logic prep;      // fold time fraction into ease operand
    logic mul_sq;    // square of ease operand
    logic mul_cube;  // cube of ease operand
    logic prog;      // form eased progress
    logic finish;    // write result register
  } ssec_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // morph still running after the time advance
    logic div_last;  // last quotient bit this cycle
    logic out_free;  // result register can take a new item
  } ssec_stat_t;

  // segment pattern, bit 0 = a
  function automatic logic [SEG_N-1:0] seg_lut(input logic [DIGIT_W-1:0] d);
    logic [SEG_N-1:0] r;
    case (d)
      4'd0:    r = 7'h3F;
      4'd1:    r = 7'h06;
      4'd2:    r = 7'h5B;
      4'd3:    r = 7'h4F;
      4'd4:    r = 7'h66;
      4'd5:    r = 7'h6D;
      4'd6:    r = 7'h7D;
      4'd7:    r = 7'h07;
      4'd8:    r = 7'h7F;
      4'd9:    r = 7'h6F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/ssec_ctrl.sv
// ----------------------------------------------------------------------------
// ssec_ctrl
// sequencer: input transfer, divider iterations, easing, result write
// ----------------------------------------------------------------------------
module ssec_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ssec_pkg::ssec_stat_t  stat_i,
  output ssec_pkg::ssec_cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_DIV  = 7'b0000010,
    ST_PREP = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_CUBE = 7'b0010000,
    ST_PROG = 7'b0100000,
    ST_FIN  = 7'b1000000
  } ssec_state_e;

  ssec_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.need_div ? ST_DIV : ST_FIN;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = ST_CUBE;
      end
      ST_CUBE: begin
        cmd_o.mul_cube = 1'b1;
        state_d        = ST_PROG;
      end
      ST_PROG: begin
        cmd_o.prog = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/ssec_dp.sv
// ----------------------------------------------------------------------------
// ssec_dp
// digit state, restoring divider, shared multiplier, segment levels
// ----------------------------------------------------------------------------
module ssec_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ssec_pkg::ssec_cmd_t                  cmd_i,
  output ssec_pkg::ssec_stat_t                 stat_o,
  input  logic                                 cfg_we_i,
  input  logic [ssec_pkg::MT_W-1:0]            cfg_data_i,
  input  logic                                 force_i,
  input  logic                                 load_i,
  input  logic [ssec_pkg::DIGIT_W-1:0]         digit_i,
  input  logic [ssec_pkg::DELTA_W-1:0]         delta_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ssec_pkg::OUT_DATA_W-1:0]      out_data_o
);

  localparam int P = ssec_pkg::PROGRESS_BITS;

  logic [ssec_pkg::MT_W-1:0]      mt_q;
  logic [ssec_pkg::DIGIT_W-1:0]   settled_q, aim_q;
  logic                           active_q;
  logic [ssec_pkg::ELAPSED_W-1:0] elapsed_q;

  logic [ssec_pkg::MT_W-1:0]      rem_q;
  logic [P-1:0]                   quo_q;
  logic [ssec_pkg::CNT_W-1:0]     cnt_q;
  logic                           hi_q;
  logic [P:0]                     x_q, s_q, c_q, p_q;

  logic                           out_valid_q;
  logic [ssec_pkg::OUT_DATA_W-1:0] out_data_q;

  // digit update and time advance for the item at the input
  logic [ssec_pkg::DIGIT_W-1:0]   dig, upd_settled, upd_aim;
  logic                           upd_active, upd_div;
  logic [ssec_pkg::ELAPSED_W-1:0] upd_elapsed, sum_sat;
  logic [ssec_pkg::ELAPSED_W:0]   sum_full;

  always_comb begin
    dig         = (digit_i > ssec_pkg::DIGIT_MAX) ? '0 : digit_i;
    upd_settled = settled_q;
    upd_aim     = aim_q;
    upd_active  = active_q;
    upd_elapsed = elapsed_q;
    upd_div     = 1'b0;
    if (force_i) begin
      upd_settled = dig;
      upd_aim     = dig;
      upd_active  = 1'b0;
      upd_elapsed = '0;
    end
    if (load_i && (dig != upd_settled)) begin
      upd_aim     = dig;
      upd_active  = 1'b1;
      upd_elapsed = '0;
    end
    sum_full = {1'b0, upd_elapsed} + {{(ssec_pkg::ELAPSED_W-ssec_pkg::DELTA_W+1){1'b0}}, delta_i};
    sum_sat  = sum_full[ssec_pkg::ELAPSED_W] ? ssec_pkg::ELAPSED_SAT
                                             : sum_full[ssec_pkg::ELAPSED_W-1:0];
    if (upd_active) begin
      if (sum_sat >= {{(ssec_pkg::ELAPSED_W-ssec_pkg::MT_W){1'b0}}, mt_q}) begin
        // morph done
        upd_settled = upd_aim;
        upd_active  = 1'b0;
        upd_elapsed = '0;
      end else begin
        upd_elapsed = sum_sat;
        upd_div     = 1'b1;
      end
    end
  end

  // restoring divider, remainder stays below the morph time
  logic [ssec_pkg::MT_W:0] rem2, rem_sub;
  logic                    rem_ge;

  assign rem2    = {rem_q, 1'b0};
  assign rem_ge  = (rem2 >= {1'b0, mt_q});
  assign rem_sub = rem2 - {1'b0, mt_q};

  // ease operand: fraction itself below one half, else 2 - 2t
  logic [P+1:0] u_full;
  assign u_full = {2'b10, {P{1'b0}}} - {1'b0, quo_q, 1'b0};

  // shared multiplier
  logic [P:0]     mul_a;
  logic [2*P+1:0] prod;
  assign mul_a = cmd_i.mul_cube ? s_q : x_q;
  assign prod  = mul_a * x_q;

  // fade levels, 255 * y >> P
  logic [P:0]   fade_out_y;
  logic [P+8:0] lvl_in_w, lvl_out_w;
  assign fade_out_y = ssec_pkg::PROG_ONE - p_q;
  assign lvl_in_w   = {p_q, 8'b0} - {8'b0, p_q};
  assign lvl_out_w  = {fade_out_y, 8'b0} - {8'b0, fade_out_y};

  logic [ssec_pkg::SEG_N-1:0]   lit_now, lit_aim;
  logic [ssec_pkg::OUT_DATA_W-1:0] res;

  always_comb begin
    lit_now = ssec_pkg::seg_lut(settled_q);
    lit_aim = ssec_pkg::seg_lut(aim_q);
    res     = '0;
    for (int k = 0; k < ssec_pkg::SEG_N; k++) begin
      if (!active_q) begin
        res[k*ssec_pkg::LEVEL_W +: ssec_pkg::LEVEL_W] =
          lit_now[k] ? ssec_pkg::LEVEL_FULL : '0;
      end else if (lit_now[k] && lit_aim[k]) begin
        res[k*ssec_pkg::LEVEL_W +: ssec_pkg::LEVEL_W] = ssec_pkg::LEVEL_FULL;
      end else if (lit_now[k]) begin
        res[k*ssec_pkg::LEVEL_W +: ssec_pkg::LEVEL_W] = lvl_out_w[P+7:P];
      end else if (lit_aim[k]) begin
        res[k*ssec_pkg::LEVEL_W +: ssec_pkg::LEVEL_W] = lvl_in_w[P+7:P];
      end
    end
    res[56 +: ssec_pkg::DIGIT_W] = settled_q;
    res[60 +: ssec_pkg::DIGIT_W] = aim_q;
    res[64]                      = active_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mt_q        <= ssec_pkg::MORPH_TIME_RESET;
      settled_q   <= '0;
      aim_q       <= '0;
      active_q    <= 1'b0;
      elapsed_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mt_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        settled_q <= upd_settled;
        aim_q     <= upd_aim;
        active_q  <= upd_active;
        elapsed_q <= upd_elapsed;
        cnt_q     <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= upd_elapsed[ssec_pkg::MT_W-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[ssec_pkg::MT_W-1:0] : rem2[ssec_pkg::MT_W-1:0];
      quo_q <= {quo_q[P-2:0], rem_ge};
    end
    if (cmd_i.prep) begin
      hi_q <= quo_q[P-1];
      x_q  <= quo_q[P-1] ? u_full[P:0] : {1'b0, quo_q};
    end
    if (cmd_i.mul_sq) begin
      s_q <= prod[2*P:P];
    end
    if (cmd_i.mul_cube) begin
      c_q <= prod[2*P:P];
    end
    if (cmd_i.prog) begin
      p_q <= hi_q ? (ssec_pkg::PROG_ONE - {1'b0, c_q[P:1]}) : {c_q[P-2:0], 2'b00};
    end
    if (cmd_i.finish) begin
      out_data_q <= res;
    end
  end

  assign stat_o.need_div = upd_div;
  assign stat_o.div_last = (cnt_q == ssec_pkg::CNT_W'(P-1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> design/seven_segment_eased_crossfade.sv
// ----------------------------------------------------------------------------
// seven_segment_eased_crossfade
// seven-segment digit with a cubic eased cross-fade between two digits
// ----------------------------------------------------------------------------
// Each input transfer may force the shown digit (tuser bit 0) or request a
// morph to a new digit (tuser bit 1), then advances time by elapsed_ms. A
// digit above 9 counts as 0. While a morph runs, elapsed/morph_time_ms goes
// through a cubic ease-in-out and sets the fade of every segment that differs
// between the two digits. One result transfer comes out per input transfer.
// Sequence: an item that leaves no morph running goes from the input
// transfer straight to the result write; an item inside a morph first passes
// the restoring divider that forms one quotient bit per cycle, then folds the
// quotient into the ease operand and makes two passes through one shared 17x17
// multiplier before the eased progress and the result write, which waits until
// the result register is free. A new input transfer is taken the cycle after
// the result is registered, while that result may still wait on m_axis_tready_i.
// morph_time_ms is written through the cfg channel (always ready) and should
// only change while the block is idle; reset value is 100.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seven_segment_eased_crossfade (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration: morph_time_ms
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ssec_pkg::MT_W-1:0]          cfg_data_i,
  // input stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [3:0] new_digit, [19:4] elapsed_ms, [23:20] zero
  input  logic [ssec_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [0] force_current, [1] load_target
  input  logic [ssec_pkg::IN_USER_W-1:0]     s_axis_tuser_i,
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] seg_a_level .. [55:48] seg_g_level, [59:56] shown_digit,
  // [63:60] goal_digit, [64] in_transition, [71:65] zero
  output logic [ssec_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o
);

  ssec_pkg::ssec_cmd_t  cmd;
  ssec_pkg::ssec_stat_t stat;

  // config register takes a write at any cycle
  assign cfg_ready_o = 1'b1;

  ssec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ssec_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .force_i     (s_axis_tuser_i[0]),
    .load_i      (s_axis_tuser_i[1]),
    .digit_i     (s_axis_tdata_i[3:0]),
    .delta_i     (s_axis_tdata_i[19:4]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // at most one datapath command per cycle
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  // a result is only written when the result register is free
  `ASSERT_IMPL(a_no_overwrite, cmd.finish, (!m_axis_tvalid_o || m_axis_tready_i),
               "result overwritten")
  // a running morph always heads for a digit other than the shown one
  `ASSERT_IMPL(a_morph_digits, (m_axis_tvalid_o && m_axis_tdata_o[64]),
               (m_axis_tdata_o[59:56] != m_axis_tdata_o[63:60]), "morph with equal digits")
  // every input transfer issues a load; input is only taken while the sequencer is idle
  `ASSERT_IMPL(a_accept_load, (s_axis_tvalid_i && s_axis_tready_o), cmd.load,
               "input transfer without load")

endmodule
